// ===== rtl/core/sos_pkg.sv =====
// ----------------------------------------------------------------------------
// sos_pkg
// character codes, opcodes and shared types of the shell operator spacer
// ----------------------------------------------------------------------------
`default_nettype none

package sos_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // flags and lookahead validity handed to the respacing logic
  typedef struct packed {
    logic operator_seen;
    logic anything_emitted;
    logic last_emitted_space;
    logic have_n;
    logic have_n2;
  } gen_ctx_t;

  // characters produced for one consumed line position
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      count;
    logic            pair;
    logic            last_space;
  } gen_res_t;

  function automatic logic is_separator(input logic [7:0] c);
    return (c == CH_PIPE) || (c == CH_GT) || (c == CH_LT) ||
           (c == CH_AMP) || (c == CH_SEMI);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return is_separator(c) || (c == CH_HASH);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sos_line_mem.sv =====
// ----------------------------------------------------------------------------
// sos_line_mem
// line buffer: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sos_line_mem #(
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sos_gen.sv =====
// ----------------------------------------------------------------------------
// sos_gen
// respacing of one line position: operator detection, pairing, padding
// ----------------------------------------------------------------------------
`default_nettype none

module sos_gen import sos_pkg::*; (
  input  logic [7:0] c,
  input  logic [7:0] n,
  input  logic [7:0] n2,
  input  gen_ctx_t   ctx,
  output gen_res_t   res
);

  always_comb begin
    logic       sym;
    logic       pair;
    logic       lead;
    logic       trail;
    logic       look_have;
    logic [7:0] look;
    logic [2:0] k;
    sym       = ctx.operator_seen && is_symbol(c);
    pair      = sym && ((c == CH_GT) || (c == CH_AMP) || (c == CH_PIPE)) &&
                ctx.have_n && (n == c);
    // after a pair the lookahead moves one further
    look_have = pair ? ctx.have_n2 : ctx.have_n;
    look      = pair ? n2 : n;
    lead      = sym && ctx.anything_emitted && !ctx.last_emitted_space;
    trail     = sym && look_have && (look != CH_SPACE);

    res.chars = '0;
    k = 3'd0;
    if (lead) begin
      res.chars[k[1:0]] = CH_SPACE;
      k = k + 3'd1;
    end
    res.chars[k[1:0]] = c;
    k = k + 3'd1;
    if (pair) begin
      res.chars[k[1:0]] = c;
      k = k + 3'd1;
    end
    if (trail) begin
      res.chars[k[1:0]] = CH_SPACE;
      k = k + 3'd1;
    end
    res.count      = k;
    res.pair       = pair;
    res.last_space = trail || (c == CH_SPACE);
  end

endmodule

`default_nettype wire

// ===== rtl/core/shell_operator_spacer.sv =====
// ----------------------------------------------------------------------------
// shell_operator_spacer
// a load gives no result; busy stays low
// a pull answered empty, or served from the pending queue with no space run to collapse,
//   gives a registered result; a pull that consumes a line position passes ST_RD1 to ST_RD3,
//   then ST_SK_RD/ST_SK_EV check each stored entry of a space run, ST_SK_RD alone at line end
// results are strobed by done for one cycle and cannot be stalled
// synchronous reset clears length, flags and queue; the buffer is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module shell_operator_spacer import sos_pkg::*; #(
  parameter int LINE_CAPACITY = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       opcode,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       done,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_empty,
  output logic       truncated
);

  localparam int LW = $clog2(LINE_CAPACITY + 1);
  localparam int AW = $clog2(LINE_CAPACITY);

  // sequencer: read current, next and next-but-one, then respace;
  // the skip states walk a run of stored spaces one entry at a time
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD1   = 6'b000010,
    ST_RD2   = 6'b000100,
    ST_RD3   = 6'b001000,
    ST_SK_RD = 6'b010000,
    ST_SK_EV = 6'b100000
  } state_t;

  state_t          state;
  logic [LW-1:0]   line_length;
  logic [LW-1:0]   read_index;
  logic            operator_seen;
  logic            last_emitted_space;
  logic            anything_emitted;
  logic            prev_space;        // stored byte before read_index is a space
  logic [2:0][7:0] pending_chars;
  logic [2:0]      pending_count;
  logic            overflow_flag;
  logic            emit_phase;
  logic [7:0]      c_reg;
  logic [7:0]      n_reg;

  // buffer ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    mem_q;

  // index arithmetic, one bit wider so that index plus two cannot wrap
  logic [LW:0]   ri_ext;
  logic [LW:0]   len_ext;
  logic [LW:0]   ri_p1;
  logic [LW:0]   ri_p2;
  logic [LW:0]   ri_adv;
  logic          have_cur;
  logic          have_n;
  logic          have_n2;
  logic          adv_more;
  logic          load_acc;
  logic          pull_acc;
  logic [LW-1:0] base_len;
  logic          room;
  logic          need_skip_pop;

  gen_ctx_t gen_ctx;
  gen_res_t gen_res;

  assign busy     = (state != ST_IDLE);
  assign load_acc = start && !busy && (opcode == OP_LOAD);
  assign pull_acc = start && !busy && (opcode == OP_PULL);

  assign ri_ext   = {1'b0, read_index};
  assign len_ext  = {1'b0, line_length};
  assign ri_p1    = ri_ext + (LW+1)'(1);
  assign ri_p2    = ri_ext + (LW+1)'(2);
  assign have_cur = (ri_ext < len_ext);
  assign have_n   = (ri_p1 < len_ext);
  assign have_n2  = (ri_p2 < len_ext);
  assign ri_adv   = ri_p1 + {{LW{1'b0}}, gen_res.pair};
  assign adv_more = (ri_adv < len_ext);

  // a load after the line end starts a new line at position zero
  assign base_len = emit_phase ? '0 : line_length;
  assign room     = (base_len < LW'(LINE_CAPACITY));

  // collapse check when the queue drains: previous stored byte was a space
  assign need_skip_pop = operator_seen && prev_space && have_cur;

  assign wr_en   = load_acc && room;
  assign wr_addr = base_len[AW-1:0];

  // read address per sequencer step; reads past the line end are not issued
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = read_index[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        rd_en   = pull_acc && emit_phase && (pending_count == 3'd0) && have_cur;
        rd_addr = read_index[AW-1:0];
      end
      ST_RD1: begin
        rd_en   = have_n;
        rd_addr = ri_p1[AW-1:0];
      end
      ST_RD2: begin
        rd_en   = have_n2;
        rd_addr = ri_p2[AW-1:0];
      end
      ST_SK_RD: begin
        rd_en   = have_cur;
        rd_addr = read_index[AW-1:0];
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = read_index[AW-1:0];
      end
    endcase
  end

  sos_line_mem #(
    .DEPTH (LINE_CAPACITY)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_char),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mem_q)
  );

  // in ST_RD3 the read data holds the byte two past the current one
  assign gen_ctx = '{
    operator_seen:      operator_seen,
    anything_emitted:   anything_emitted,
    last_emitted_space: last_emitted_space,
    have_n:             have_n,
    have_n2:            have_n2
  };

  sos_gen u_gen (
    .c   (c_reg),
    .n   (n_reg),
    .n2  (mem_q),
    .ctx (gen_ctx),
    .res (gen_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      line_length        <= '0;
      read_index         <= '0;
      operator_seen      <= 1'b0;
      last_emitted_space <= 1'b0;
      anything_emitted   <= 1'b0;
      prev_space         <= 1'b0;
      pending_count      <= 3'd0;
      overflow_flag      <= 1'b0;
      emit_phase         <= 1'b0;
      done               <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (load_acc) begin
            done <= 1'b0;
            if (emit_phase) begin
              // new line: drop readout state of the old one
              read_index         <= '0;
              last_emitted_space <= 1'b0;
              anything_emitted   <= 1'b0;
              prev_space         <= 1'b0;
              pending_count      <= 3'd0;
              overflow_flag      <= 1'b0;
            end
            if (room) begin
              line_length <= base_len + LW'(1);
              // a new line forgets the operators of the old one
              operator_seen <= (operator_seen && !emit_phase) || is_separator(in_char);
            end else begin
              // over capacity: byte dropped, in_last still ends the line
              overflow_flag <= 1'b1;
            end
            emit_phase <= in_last;
          end else if (pull_acc) begin
            if (!emit_phase || ((pending_count == 3'd0) && !have_cur)) begin
              // nothing to give: line still loading or fully read
              done      <= 1'b1;
              out_char  <= 8'h00;
              out_last  <= 1'b0;
              out_empty <= 1'b1;
              truncated <= overflow_flag;
            end else if (pending_count != 3'd0) begin
              // serve from the queue
              out_char      <= pending_chars[0];
              pending_chars <= {8'h00, pending_chars[2], pending_chars[1]};
              pending_count <= pending_count - 3'd1;
              out_empty     <= 1'b0;
              truncated     <= overflow_flag;
              if ((pending_count == 3'd1) && need_skip_pop) begin
                done  <= 1'b0;
                state <= ST_SK_RD;
              end else begin
                done     <= 1'b1;
                out_last <= (pending_count == 3'd1) && !have_cur;
              end
            end else begin
              // queue empty: fetch the next line position
              done  <= 1'b0;
              state <= ST_RD1;
            end
          end else begin
            done <= 1'b0;
          end
        end

        ST_RD1: begin
          done  <= 1'b0;
          c_reg <= mem_q;
          state <= ST_RD2;
        end

        ST_RD2: begin
          done  <= 1'b0;
          n_reg <= mem_q;
          state <= ST_RD3;
        end

        ST_RD3: begin
          // first produced byte goes out, the rest wait in the queue
          out_char           <= gen_res.chars[0];
          pending_chars      <= {gen_res.chars[3], gen_res.chars[2], gen_res.chars[1]};
          pending_count      <= gen_res.count - 3'd1;
          read_index         <= ri_adv[LW-1:0];
          anything_emitted   <= 1'b1;
          last_emitted_space <= gen_res.last_space;
          prev_space         <= (c_reg == CH_SPACE);
          out_empty          <= 1'b0;
          truncated          <= overflow_flag;
          if ((gen_res.count == 3'd1) && operator_seen &&
              (c_reg == CH_SPACE) && adv_more) begin
            done  <= 1'b0;
            state <= ST_SK_RD;
          end else begin
            done     <= 1'b1;
            out_last <= (gen_res.count == 3'd1) && !adv_more;
            state    <= ST_IDLE;
          end
        end

        ST_SK_RD: begin
          if (have_cur) begin
            done  <= 1'b0;
            state <= ST_SK_EV;
          end else begin
            // run of spaces reached the line end
            done     <= 1'b1;
            out_last <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        ST_SK_EV: begin
          if (mem_q == CH_SPACE) begin
            done       <= 1'b0;
            read_index <= ri_p1[LW-1:0];
            state      <= ST_SK_RD;
          end else begin
            done     <= 1'b1;
            out_last <= 1'b0;
            state    <= ST_IDLE;
          end
        end

        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result is either a byte or an empty answer, never the last of an empty line
  a_empty_not_last: assert property (@(posedge clk) disable iff (rst)
    done |-> !(out_empty && out_last))
    else $error("empty result marked as last");

  // readout never runs past the stored line
  a_index_in_line: assert property (@(posedge clk) disable iff (rst)
    read_index <= line_length)
    else $error("read index beyond line length");

  // a load transaction never causes a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == OP_LOAD)) |=> !done)
    else $error("result strobed after a load");

  // queued bytes exist only while reading out a line
  a_queue_in_emit: assert property (@(posedge clk) disable iff (rst)
    (pending_count != 3'd0) |-> (emit_phase && anything_emitted))
    else $error("pending bytes outside readout");

  // the sequencer only works on a line that has ended
  a_busy_in_emit: assert property (@(posedge clk) disable iff (rst)
    busy |-> emit_phase)
    else $error("busy while loading");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the shell operator spacer: lines are loaded one
// character per transaction, then pulled back; a behavioral predictor of the
// respacing rules tracks every accepted transaction and each strobed result
// is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------

module tb;
  import sos_pkg::*;

  localparam int LINE_CAP = 1024;

  // one strobed result of a pull
  typedef struct packed {
    logic [7:0] code;
    logic       ends_line;
    logic       none_left;
    logic       cut;
  } spaced_char_t;

  typedef logic [7:0] char_q_t[$];

  // stimulus side of the block
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       opcode = OP_LOAD;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       busy;
  logic       done;
  logic [7:0] out_char;
  logic       out_last;
  logic       out_empty;
  logic       truncated;

  // predicted respacer state
  logic [7:0]   mem_line [LINE_CAP];
  int unsigned  mem_len;
  int unsigned  rd_pos;
  bit           sep_in_line;
  bit           prev_out_space;
  bit           any_out;
  bit           overflowed;
  bit           drain_mode;
  logic [7:0]   staged[$];

  // predictions waiting for their result, oldest first
  spaced_char_t expected_chars[$];
  spaced_char_t newest_char;

  int idle_pct;
  int items_sent;
  int failures;

  shell_operator_spacer DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .in_char   (in_char),
    .in_last   (in_last),
    .done      (done),
    .out_char  (out_char),
    .out_last  (out_last),
    .out_empty (out_empty),
    .truncated (truncated)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // characters that switch a line into respacing mode
  function automatic bit splits_command(logic [7:0] c);
    return c inside {CH_PIPE, CH_GT, CH_LT, CH_AMP, CH_SEMI};
  endfunction

  // characters that get a space on each side once respacing is on
  function automatic bit takes_spacing(logic [7:0] c);
    return splits_command(c) || (c == CH_HASH);
  endfunction

  // queue one output character; at most four wait at a time
  function automatic void stage(logic [7:0] c);
    if (staged.size() < 4) staged.push_back(c);
    any_out = 1'b1;
    prev_out_space = (c == CH_SPACE);
  endfunction

  // in respacing mode a stored space right after a stored space is dropped
  function automatic void collapse_spaces();
    if (!sep_in_line) return;
    while (rd_pos < mem_len && rd_pos > 0 && mem_line[rd_pos] == CH_SPACE &&
           mem_line[rd_pos - 1] == CH_SPACE)
      rd_pos++;
  endfunction

  // consume one line position (two for a doubled operator)
  function automatic void expand_position();
    logic [7:0] c;
    bit         doubled;
    if (rd_pos >= mem_len) return;
    c = mem_line[rd_pos];
    if (!sep_in_line || !takes_spacing(c)) begin
      stage(c);
      rd_pos++;
      return;
    end
    doubled = (c inside {CH_GT, CH_AMP, CH_PIPE}) && rd_pos + 1 < mem_len &&
              mem_line[rd_pos + 1] == c;
    if (doubled) rd_pos++;
    // space in front unless at the start or already after a space
    if (any_out && !prev_out_space) stage(CH_SPACE);
    stage(c);
    if (doubled) stage(c);
    // space behind unless the operator ends the line or a space follows
    if (rd_pos + 1 < mem_len && mem_line[rd_pos + 1] != CH_SPACE) stage(CH_SPACE);
    rd_pos++;
  endfunction

  function automatic void restart_line();
    mem_len = 0;
    rd_pos = 0;
    sep_in_line = 1'b0;
    prev_out_space = 1'b0;
    any_out = 1'b0;
    overflowed = 1'b0;
    drain_mode = 1'b0;
    staged.delete();
  endfunction

  function automatic void predict_load(logic [7:0] c, logic lst);
    // a load after the line has ended begins a fresh line
    if (drain_mode) restart_line();
    if (mem_len < LINE_CAP) begin
      mem_line[mem_len] = c;
      mem_len++;
      if (splits_command(c)) sep_in_line = 1'b1;
    end else begin
      // past capacity the byte is lost, but its end mark still counts
      overflowed = 1'b1;
    end
    if (lst) drain_mode = 1'b1;
  endfunction

  function automatic spaced_char_t predict_pull();
    spaced_char_t r;
    if (drain_mode && staged.size() == 0) begin
      collapse_spaces();
      expand_position();
    end
    r.cut = overflowed;
    // still loading, or nothing left of the line
    if (!drain_mode || staged.size() == 0) begin
      r.code = 8'h00;
      r.ends_line = 1'b0;
      r.none_left = 1'b1;
      return r;
    end
    r.code = staged.pop_front();
    r.none_left = 1'b0;
    if (staged.size() == 0) collapse_spaces();
    r.ends_line = (staged.size() == 0) && (rd_pos >= mem_len);
    return r;
  endfunction

  // ---------------------------------------------------------------- transport

  // one transaction; called right after a rising edge, returns at the edge
  // that accepted it with start still high so the next one can follow
  task automatic send_item(logic op, logic [7:0] c, logic lst);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    opcode  <= op;
    in_char <= c;
    in_last <= lst;
    do @(posedge clk); while (busy);
    if (op == OP_PULL) begin
      newest_char = predict_pull();
      expected_chars.push_back(newest_char);
    end else begin
      predict_load(c, lst);
    end
    items_sent++;
  endtask

  // character and end fields are don't-care on a pull, so toggle them anyway
  task automatic pull_char();
    send_item(OP_PULL, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic load_line(char_q_t chars);
    foreach (chars[i]) send_item(OP_LOAD, chars[i], i == chars.size() - 1);
  endtask

  // pull until the line reports its final character or runs dry
  task automatic drain_line(int extra_pulls);
    do pull_char(); while (!newest_char.ends_line && !newest_char.none_left);
    repeat (extra_pulls) pull_char();
  endtask

  function automatic char_q_t to_chars(string s);
    char_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    return q;
  endfunction

  // weighted toward operators and spaces; a plain line never gets a separator
  function automatic logic [7:0] pick_char(bit plain);
    logic [7:0] ops [6];
    int         roll;
    logic [7:0] c;
    ops = '{CH_PIPE, CH_GT, CH_LT, CH_AMP, CH_SEMI, CH_HASH};
    roll = $urandom_range(19);
    if (roll < 6)       c = plain ? CH_HASH : ops[$urandom_range(5)];
    else if (roll < 10) c = CH_SPACE;
    else if (roll < 18) c = 8'h61 + 8'($urandom_range(25));
    else                c = 8'($urandom_range(255));
    if (plain && splits_command(c)) c = 8'h7A;
    return c;
  endfunction

  // ---------------------------------------------------------------- checking

  // results are sampled at the edge that ends their strobe cycle and compared
  // at the falling edge, once any prediction made at that edge is in place
  always begin : result_monitor
    spaced_char_t got;
    spaced_char_t want;
    bit           strobed;
    @(posedge clk);
    strobed = done && !rst;
    got = '{out_char, out_last, out_empty, truncated};
    @(negedge clk);
    if (strobed) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_char %02h out_last %0b out_empty %0b",
               got.code, got.ends_line, got.none_left);
        failures++;
      end else begin
        want = expected_chars.pop_front();
        if (got.code !== want.code) begin
          $error("out_char: expected %02h, got %02h", want.code, got.code);
          failures++;
        end
        if (got.ends_line !== want.ends_line) begin
          $error("out_last: expected %0b, got %0b", want.ends_line, got.ends_line);
          failures++;
        end
        if (got.none_left !== want.none_left) begin
          $error("out_empty: expected %0b, got %0b", want.none_left, got.none_left);
          failures++;
        end
        if (got.cut !== want.cut) begin
          $error("truncated: expected %0b, got %0b", want.cut, got.cut);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // pulls with no ended line: right after reset and in the middle of a load
  task automatic test_pull_before_line_end();
    pull_char();
    send_item(OP_LOAD, 8'h71, 1'b0);
    pull_char();
    send_item(OP_LOAD, 8'h72, 1'b1);
    drain_line(0);
  endtask

  // no separator: spaces and the hash pass through untouched, extremes of the byte
  task automatic test_plain_line();
    load_line('{8'h00, 8'hFF, CH_SPACE, CH_SPACE, CH_HASH});
    drain_line(1);
  endtask

  // leading space kept, doubled and single operators, space runs, operator at end
  task automatic test_operator_spacing();
    load_line(to_chars(" >>a  |b"));
    drain_line(0);
    load_line(to_chars("a&&b||<;#&"));
    drain_line(0);
  endtask

  // new load while the old line is half read out
  task automatic test_reload_during_readout();
    load_line(to_chars("x;y"));
    pull_char();
    pull_char();
    load_line(to_chars("z"));
    drain_line(1);
  endtask

  // a line longer than the buffer: extra bytes dropped, truncated on every pull
  task automatic test_line_overflow();
    char_q_t chars;
    repeat (LINE_CAP + 6) chars.push_back(pick_char(1'b0));
    load_line(chars);
    repeat (24) pull_char();
  endtask

  // random lines with random readout depth, stray pulls and idle phases
  task automatic test_random_lines(int target);
    int      first;
    int      line_no;
    int      len;
    bit      plain;
    char_q_t chars;
    first = items_sent;
    line_no = 0;
    while (items_sent - first < target) begin
      // idle phases rotate, two of them with no gaps at all
      case ((line_no / 2) % 4)
        0: idle_pct = 0;
        1: idle_pct = 72;
        2: idle_pct = 22;
        default: idle_pct = 0;
      endcase
      len = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      plain = ($urandom_range(3) == 0);
      chars.delete();
      repeat (len) chars.push_back(pick_char(plain));
      foreach (chars[i]) begin
        // stray pull while the line is still coming in
        if (i > 0 && $urandom_range(19) == 0) pull_char();
        send_item(OP_LOAD, chars[i], i == len - 1);
      end
      if ($urandom_range(9) < 2) begin
        // cut the readout short; the next line's first load restarts it
        repeat ($urandom_range(0, len)) pull_char();
      end else begin
        drain_line(($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
      end
      line_no++;
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    restart_line();
    idle_pct = 0;
    items_sent = 0;
    failures = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_pull_before_line_end();
    test_plain_line();
    idle_pct = 22;
    test_operator_spacing();
    test_reload_during_readout();
    test_line_overflow();
    test_random_lines(1300 - items_sent);

    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    // room for a late stray result to show up
    repeat (40) @(posedge clk);
    if (failures == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sos_pkg.sv
rtl/core/sos_line_mem.sv
rtl/core/sos_gen.sv
rtl/core/shell_operator_spacer.sv
test/tb.sv
